FILE: src/pcibar_pkg.sv
// shared types, codes and layout decode for the pci bar register block
package pcibar_pkg;

    // bar type codes as held in the layout register
    typedef enum logic [2:0] {
        BT_UNUSED = 3'd0,
        BT_MMIO32 = 3'd1,
        BT_MMIO64 = 3'd2,
        BT_UPPER  = 3'd3,
        BT_IO     = 3'd4
    } bar_type_t;

    // access sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    // configuration register indexes
    localparam logic [1:0] CFG_BRIDGE_HEADER = 2'd0;
    localparam logic [1:0] CFG_BAR_LAYOUT    = 2'd1;
    localparam logic [1:0] CFG_ROM_SIZE_LOG2 = 2'd2;

    // access width codes
    localparam logic [1:0] W_BYTE  = 2'd0;
    localparam logic [1:0] W_HALF  = 2'd1;
    localparam logic [1:0] W_WORD  = 2'd2;
    localparam logic [1:0] W_DWORD = 2'd3;

    // header offsets and fixed sizes
    localparam logic [7:0] BAR_BASE_OFF  = 8'h10;
    localparam logic [7:0] ROM_OFF_EP    = 8'h30;
    localparam logic [7:0] ROM_OFF_BR    = 8'h38;
    localparam logic [4:0] ROM_LG_MIN    = 5'd11;
    localparam int         LAY_BITS      = 10;
    localparam int         LAYOUT_W      = 60;
    localparam int         BRIDGE_BARS   = 2;

    // decoded per-bar layout
    typedef struct packed {
        bar_type_t  typ;
        logic       pref;
        logic [5:0] lg;
    } bar_lay_t;

    function automatic bar_lay_t lay_decode(logic [LAY_BITS-1:0] f, logic first);
        bar_lay_t l;
        l.pref = f[3];
        l.lg   = f[9:4];
        case (f[2:0])
            BT_MMIO32: l.typ = BT_MMIO32;
            BT_MMIO64: l.typ = BT_MMIO64;
            BT_UPPER:  l.typ = first ? BT_UNUSED : BT_UPPER;
            BT_IO:     l.typ = BT_IO;
            default:   l.typ = BT_UNUSED;
        endcase
        return l;
    endfunction

endpackage

FILE: src/pcibar_ram.sv
// bar address memory: one write port, one registered read port, per-entry valid bits
module pcibar_ram #(
    parameter int DEPTH = 6,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata,
    output logic          rvalid
);

    logic [63:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]      rdata_reg;
    logic             rvalid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // valid bits stand in for the zero reset of the entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

FILE: src/pci_bar_config_registers.sv
// Emulated PCI BAR and expansion ROM registers of a configuration header.
// A word taken in the idle state passes the read and execute states into the
// output word register, waiting in execute while the output is stalled. No new
// word is taken until the read-modify-write of the bar address memory is done.
// Reset clears all bar addresses (through per-entry valid bits), the ROM state
// and the configuration registers at once; no clearing pass is needed.
module pci_bar_config_registers
    import pcibar_pkg::*;
#(
    parameter int BAR_COUNT = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [LAYOUT_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [7:0]          reg_offset,
    input  logic [1:0]          width_code,
    input  logic [31:0]         write_data,
    input  logic                memory_decode_on,
    input  logic                io_decode_on,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                claimed,
    output logic [31:0]         read_data,
    output logic                write_dropped,
    output logic                rom_unmap,
    output logic                rom_map,
    output logic                rom_hw_enable_pulse
);

    localparam int IDX_W      = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
    localparam int BRIDGE_CNT = (BAR_COUNT < BRIDGE_BARS) ? BAR_COUNT : BRIDGE_BARS;

    // configuration registers
    logic                bridge_reg;
    logic [LAYOUT_W-1:0] layout_reg;
    logic [4:0]          rom_size_reg;

    // rom state
    logic [31:0] rom_base_reg;
    logic        rom_guest_reg;
    logic        rom_hw_reg;

    // latched access
    state_t     state_reg, state_next;
    logic       wr_reg;
    logic [7:0] off_reg;
    logic [1:0] width_reg;
    logic [31:0] data_reg;
    logic       mem_on_reg;
    logic       io_on_reg;
    logic       is_rom_reg;
    logic       bar_hit_reg;
    logic [IDX_W-1:0] idx_reg;

    // result registers
    logic        out_valid_reg;
    logic        claimed_reg;
    logic [31:0] read_data_reg;
    logic        dropped_reg;
    logic        unmap_reg;
    logic        map_reg;
    logic        pulse_reg;

    // sequencer controls
    logic accept;
    logic exec_go;
    logic out_free;

    // memory port
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [63:0]      mem_wdata;
    logic [63:0]      mem_rdata;
    logic             mem_rvalid;

    // offset decode at accept
    logic [3:0]       nbars;
    logic [7:0]       rom_off;
    logic [8:0]       bar_limit;
    logic [7:0]       bar_off;
    logic             in_is_rom;
    logic             in_is_bar;
    logic [IDX_W-1:0] in_idx;

    // execute datapath
    logic [IDX_W-1:0] jdx;
    bar_lay_t         lay_i;
    bar_lay_t         lay_j;
    logic [63:0]      cur;
    logic [63:0]      mask_i;
    logic [63:0]      mask_j;
    logic [31:0]      bar_val;
    logic [31:0]      reg_val;
    logic [31:0]      rd_sized;
    logic             misaligned;
    logic [4:0]       rom_lg;
    logic             res_claimed;
    logic [31:0]      res_rd;
    logic             res_dropped;
    logic             res_unmap;
    logic             res_map;
    logic             res_pulse;
    logic             bar_we;
    logic             rom_we;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_reg   <= 1'b0;
            layout_reg   <= '0;
            rom_size_reg <= ROM_LG_MIN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BRIDGE_HEADER: bridge_reg   <= cfg_data[0];
                CFG_BAR_LAYOUT:    layout_reg   <= cfg_data;
                CFG_ROM_SIZE_LOG2: rom_size_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // claim decode on the incoming word
    always_comb
    begin
        nbars     = bridge_reg ? 4'(BRIDGE_CNT) : 4'(BAR_COUNT);
        rom_off   = bridge_reg ? ROM_OFF_BR : ROM_OFF_EP;
        bar_limit = {1'b0, BAR_BASE_OFF} + {3'b000, nbars, 2'b00};
        bar_off   = reg_offset - BAR_BASE_OFF;
        in_is_rom = (reg_offset[7:2] == rom_off[7:2]);
        in_is_bar = (reg_offset >= BAR_BASE_OFF) && ({1'b0, reg_offset} < bar_limit);
        in_idx    = in_is_bar ? bar_off[IDX_W+1:2] : '0;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        in_stall = 1'b1;
        exec_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_READ: ;
            ST_EXEC: exec_go = out_free;
            default: ;
        endcase
    end

    assign accept = in_valid && !in_stall;

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_reg      <= mode;
            off_reg     <= reg_offset;
            width_reg   <= width_code;
            data_reg    <= write_data;
            mem_on_reg  <= memory_decode_on;
            io_on_reg   <= io_decode_on;
            is_rom_reg  <= in_is_rom;
            bar_hit_reg <= in_is_bar;
            idx_reg     <= in_idx;
        end
    end

    // layout of the addressed bar and of the one below it
    always_comb
    begin
        jdx    = (idx_reg == '0) ? '0 : idx_reg - 1'b1;
        lay_i  = lay_decode(layout_reg[LAY_BITS*int'(idx_reg) +: LAY_BITS], idx_reg == '0);
        lay_j  = lay_decode(layout_reg[LAY_BITS*int'(jdx) +: LAY_BITS], jdx == '0);
        mask_i = {64{1'b1}} << lay_i.lg;
        mask_j = {64{1'b1}} << lay_j.lg;
    end

    // an upper half lives in the entry of the bar below
    assign mem_addr = (lay_i.typ == BT_UPPER) ? jdx : idx_reg;

    pcibar_ram #(
        .DEPTH (BAR_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (mem_we),
        .waddr  (mem_addr),
        .wdata  (mem_wdata),
        .raddr  (mem_addr),
        .rdata  (mem_rdata),
        .rvalid (mem_rvalid)
    );

    // read value of the addressed register
    always_comb
    begin
        cur = mem_rvalid ? mem_rdata : 64'd0;
        case (lay_i.typ)
            BT_UPPER:  bar_val = cur[63:32];
            BT_MMIO32: bar_val = cur[31:0] | {28'd0, lay_i.pref, 3'b000};
            BT_MMIO64: bar_val = cur[31:0] | {28'd0, lay_i.pref, 3'b100};
            BT_IO:     bar_val = cur[31:0] | 32'd1;
            default:   bar_val = 32'd0;
        endcase
        reg_val = is_rom_reg ? (rom_base_reg | {31'd0, rom_guest_reg}) : bar_val;
        case (width_reg)
            W_BYTE:  rd_sized = {24'd0, reg_val[7:0]};
            W_HALF:  rd_sized = {16'd0, reg_val[15:0]};
            default: rd_sized = reg_val;
        endcase
        case (width_reg)
            W_BYTE:  misaligned = 1'b0;
            W_HALF:  misaligned = off_reg[0];
            W_WORD:  misaligned = off_reg[1:0] != 2'b00;
            default: misaligned = off_reg[2:0] != 3'b000;
        endcase
        rom_lg = (rom_size_reg < ROM_LG_MIN) ? ROM_LG_MIN : rom_size_reg;
    end

    // result and write-back selection
    always_comb
    begin
        res_claimed = is_rom_reg || bar_hit_reg;
        res_rd      = 32'd0;
        res_dropped = 1'b0;
        res_unmap   = 1'b0;
        res_map     = 1'b0;
        res_pulse   = 1'b0;
        bar_we      = 1'b0;
        rom_we      = 1'b0;
        mem_wdata   = cur;
        // bar write value by type
        case (lay_i.typ)
            BT_IO:     mem_wdata = {48'd0, data_reg[15:0] & mask_i[15:0]};
            BT_UPPER:  mem_wdata = {data_reg & mask_j[63:32], cur[31:0]};
            BT_MMIO32: mem_wdata = {32'd0, data_reg & mask_i[31:0]};
            BT_MMIO64: mem_wdata = {cur[63:32], data_reg & mask_i[31:0]};
            default:   mem_wdata = cur;
        endcase
        if (!res_claimed)
        begin
            res_claimed = 1'b0;
        end
        else if (misaligned)
        begin
            res_dropped = wr_reg;
        end
        else if (!wr_reg)
        begin
            res_rd = rd_sized;
        end
        else if (is_rom_reg)
        begin
            rom_we    = 1'b1;
            res_unmap = rom_guest_reg && mem_on_reg;
            res_map   = data_reg[0] && mem_on_reg;
            res_pulse = data_reg[0] && !rom_hw_reg;
        end
        else if (width_reg != W_WORD)
        begin
            res_dropped = 1'b1;
        end
        else
        begin
            case (lay_i.typ)
                BT_UNUSED: ;
                BT_IO:
                begin
                    res_dropped = io_on_reg;
                    bar_we      = !io_on_reg;
                end
                default:
                begin
                    res_dropped = mem_on_reg;
                    bar_we      = !mem_on_reg;
                end
            endcase
        end
    end

    assign mem_we = exec_go && bar_we;

    // rom state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_base_reg  <= 32'd0;
            rom_guest_reg <= 1'b0;
            rom_hw_reg    <= 1'b0;
        end
        else if (exec_go && rom_we)
        begin
            rom_base_reg  <= data_reg & ({32{1'b1}} << rom_lg);
            rom_guest_reg <= data_reg[0];
            if (data_reg[0])
            begin
                rom_hw_reg <= 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            claimed_reg   <= res_claimed;
            read_data_reg <= res_rd;
            dropped_reg   <= res_dropped;
            unmap_reg     <= res_unmap;
            map_reg       <= res_map;
            pulse_reg     <= res_pulse;
        end
    end

    assign out_valid           = out_valid_reg;
    assign claimed             = claimed_reg;
    assign read_data           = read_data_reg;
    assign write_dropped       = dropped_reg;
    assign rom_unmap           = unmap_reg;
    assign rom_map             = map_reg;
    assign rom_hw_enable_pulse = pulse_reg;

endmodule

FILE: tb/tb_pci_bar_config_registers.sv
// self-checking testbench for the emulated pci bar and expansion rom registers
`timescale 1ns / 1ps

module tb_pci_bar_config_registers;
    import pcibar_pkg::*;

    localparam int NUM_BARS = 6;

    // access direction codes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // one config access word and the reply word it causes
    typedef struct packed {
        logic        mode;
        logic [7:0]  offset;
        logic [1:0]  width;
        logic [31:0] data;
        logic        mem_on;
        logic        io_on;
    } access_t;

    typedef struct packed {
        logic        claimed;
        logic [31:0] rdata;
        logic        dropped;
        logic        unmap;
        logic        mapped;
        logic        pulse;
    } reply_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // dut ports
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [LAYOUT_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic                mode             = 1'b0;
    logic [7:0]          reg_offset       = '0;
    logic [1:0]          width_code       = '0;
    logic [31:0]         write_data       = '0;
    logic                memory_decode_on = 1'b0;
    logic                io_decode_on     = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                claimed;
    logic [31:0]         read_data;
    logic                write_dropped;
    logic                rom_unmap;
    logic                rom_map;
    logic                rom_hw_enable_pulse;

    pci_bar_config_registers #(
        .BAR_COUNT(NUM_BARS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .reg_offset         (reg_offset),
        .width_code         (width_code),
        .write_data         (write_data),
        .memory_decode_on   (memory_decode_on),
        .io_decode_on       (io_decode_on),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .claimed            (claimed),
        .read_data          (read_data),
        .write_dropped      (write_dropped),
        .rom_unmap          (rom_unmap),
        .rom_map            (rom_map),
        .rom_hw_enable_pulse(rom_hw_enable_pulse)
    );

    // shadow of the configuration registers
    logic                hdr_bridge = 1'b0;
    logic [LAYOUT_W-1:0] layout_q   = '0;
    logic [4:0]          rom_lg_q   = ROM_LG_MIN;

    // shadow of the emulated register state
    logic [63:0] bar_addr [NUM_BARS];
    logic [31:0] rom_base     = '0;
    logic        rom_guest_en = 1'b0;
    logic        rom_hw_en    = 1'b0;

    access_t pending_accesses [$];
    reply_t  expected_results [$];
    access_t presented;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;

    initial begin
        for (int i = 0; i < NUM_BARS; i++)
        begin
            bar_addr[i] = '0;
        end
    end

    // effective type of bar i under the current layout
    function automatic bar_type_t bar_kind(int i);
        logic [2:0] t;
        t = layout_q[LAY_BITS*i +: 3];
        case (t)
            BT_MMIO32: return BT_MMIO32;
            BT_MMIO64: return BT_MMIO64;
            BT_UPPER:  return (i == 0) ? BT_UNUSED : BT_UPPER;
            BT_IO:     return BT_IO;
            default:   return BT_UNUSED;
        endcase
    endfunction

    // writable address bits of bar i
    function automatic logic [63:0] bar_mask(int i);
        logic [5:0] lg;
        lg = layout_q[LAY_BITS*i+4 +: 6];
        return {64{1'b1}} << lg;
    endfunction

    function automatic logic [31:0] bar_value(int i);
        logic [31:0] lo;
        logic [31:0] pf;
        lo = bar_addr[i][31:0];
        pf = layout_q[LAY_BITS*i+3] ? 32'h8 : 32'h0;
        case (bar_kind(i))
            BT_UPPER:  return bar_addr[i-1][63:32];
            BT_MMIO32: return lo | pf;
            BT_MMIO64: return lo | 32'h4 | pf;
            BT_IO:     return lo | 32'h1;
            default:   return 32'h0;
        endcase
    endfunction

    // aligned 32-bit bar write, returns the dropped flag
    function automatic logic bar_store(int i, logic [31:0] v, logic mem_on, logic io_on);
        bar_type_t   t;
        logic [63:0] m;
        t = bar_kind(i);
        if (t == BT_UNUSED)
            return 1'b0;
        if (t == BT_IO)
        begin
            if (io_on)
                return 1'b1;
            m = bar_mask(i);
            bar_addr[i] = {48'h0, v[15:0] & m[15:0]};
            return 1'b0;
        end
        if (mem_on)
            return 1'b1;
        if (t == BT_UPPER)
        begin
            // upper half lands in the bar below, under its size mask
            m = bar_mask(i - 1);
            bar_addr[i-1][63:32] = v & m[63:32];
        end
        else if (t == BT_MMIO32)
        begin
            m = bar_mask(i);
            bar_addr[i] = {32'h0, v & m[31:0]};
        end
        else
        begin
            m = bar_mask(i);
            bar_addr[i][31:0] = v & m[31:0];
        end
        return 1'b0;
    endfunction

    // expected reply to one access, updates the shadow state
    function automatic reply_t emulate_access(access_t a);
        reply_t      r;
        int          nbars;
        int          idx;
        logic [7:0]  rom_off;
        logic [7:0]  amask;
        logic        is_rom;
        logic        is_bar;
        logic [31:0] v;
        logic [4:0]  lg;
        r       = '0;
        nbars   = hdr_bridge ? BRIDGE_BARS : NUM_BARS;
        rom_off = hdr_bridge ? ROM_OFF_BR : ROM_OFF_EP;
        is_rom  = (a.offset >= rom_off) && (a.offset <= rom_off + 3);
        is_bar  = (a.offset >= BAR_BASE_OFF) && (a.offset < BAR_BASE_OFF + 4 * nbars);
        if (!is_rom && !is_bar)
            return r;
        r.claimed = 1'b1;
        idx       = (int'(a.offset) - int'(BAR_BASE_OFF)) >> 2;
        amask     = (8'd1 << a.width) - 8'd1;
        if ((a.offset & amask) != 8'd0)
        begin
            // misaligned: reads zero, writes dropped
            r.dropped = (a.mode == MODE_WRITE);
        end
        else if (a.mode == MODE_READ)
        begin
            // narrow reads return the low bytes of the register
            v = is_rom ? (rom_base | {31'h0, rom_guest_en}) : bar_value(idx);
            case (a.width)
                W_BYTE:  r.rdata = v & 32'hff;
                W_HALF:  r.rdata = v & 32'hffff;
                default: r.rdata = v;
            endcase
        end
        else if (is_rom)
        begin
            lg           = (rom_lg_q < ROM_LG_MIN) ? ROM_LG_MIN : rom_lg_q;
            r.unmap      = rom_guest_en && a.mem_on;
            rom_guest_en = a.data[0];
            rom_base     = a.data & (32'hffffffff << lg);
            if (rom_guest_en)
            begin
                r.mapped = a.mem_on;
                if (!rom_hw_en)
                begin
                    r.pulse   = 1'b1;
                    rom_hw_en = 1'b1;
                end
            end
        end
        else if (a.width != W_WORD)
        begin
            r.dropped = 1'b1;
        end
        else
        begin
            r.dropped = bar_store(idx, a.data, a.mem_on, a.io_on);
        end
        return r;
    endfunction

    // random layout, mostly well-formed 64-bit pairs and plain bars
    function automatic logic [LAYOUT_W-1:0] random_layout();
        logic [LAYOUT_W-1:0] lay;
        logic [2:0]          t;
        logic [5:0]          lg;
        int                  i;
        int                  pick;
        lay = '0;
        i   = 0;
        while (i < NUM_BARS)
        begin
            if (i < NUM_BARS - 1 && $urandom_range(2) == 0)
            begin
                lay[LAY_BITS*i +: LAY_BITS] =
                    {6'($urandom_range(63)), 1'($urandom_range(1)), BT_MMIO64};
                lay[LAY_BITS*(i+1) +: LAY_BITS] =
                    {6'($urandom_range(63)), 1'($urandom_range(1)), BT_UPPER};
                i += 2;
            end
            else
            begin
                pick = $urandom_range(9);
                case (pick)
                    0:       t = BT_UNUSED;
                    1:       t = 3'($urandom_range(7, 5));
                    2:       t = BT_UPPER;
                    3:       t = BT_MMIO64;
                    4, 5, 6: t = BT_MMIO32;
                    default: t = BT_IO;
                endcase
                lg = (t == BT_IO) ? 6'($urandom_range(8)) : 6'($urandom_range(63));
                lay[LAY_BITS*i +: LAY_BITS] = {lg, 1'($urandom_range(1)), t};
                i += 1;
            end
        end
        return lay;
    endfunction

    // random access aimed mostly at the claimed window
    function automatic access_t random_access();
        access_t    a;
        int         nbars;
        int         pick;
        logic [7:0] rom_off;
        nbars   = hdr_bridge ? BRIDGE_BARS : NUM_BARS;
        rom_off = hdr_bridge ? ROM_OFF_BR : ROM_OFF_EP;
        pick    = $urandom_range(9);
        if (pick == 0)
            a.offset = 8'($urandom_range(255));
        else if (pick <= 2)
            a.offset = rom_off + 8'($urandom_range(3));
        else
        begin
            a.offset = BAR_BASE_OFF + 8'($urandom_range(4 * nbars - 1));
            if ($urandom_range(3) != 0)
                a.offset[1:0] = 2'b00;
        end
        a.mode  = $urandom_range(1) ? MODE_WRITE : MODE_READ;
        a.width = ($urandom_range(9) < 6) ? W_WORD : 2'($urandom_range(3));
        pick    = $urandom_range(9);
        if (pick == 0)
            a.data = '1;
        else if (pick == 1)
            a.data = '0;
        else
            a.data = $urandom;
        a.mem_on = ($urandom_range(3) == 0);
        a.io_on  = ($urandom_range(3) == 0);
        return a;
    endfunction

    task automatic queue_access(logic m, logic [7:0] off, logic [1:0] w, logic [31:0] d,
                                logic mem_on, logic io_on);
        access_t a;
        a = '{mode: m, offset: off, width: w, data: d, mem_on: mem_on, io_on: io_on};
        pending_accesses.push_back(a);
    endtask

    // config register write, only while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [LAYOUT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BRIDGE_HEADER: hdr_bridge = val[0];
            CFG_BAR_LAYOUT:    layout_q   = val;
            CFG_ROM_SIZE_LOG2: rom_lg_q   = val[4:0];
            default:           ;
        endcase
    endtask

    // wait until every queued word has been sent and answered
    task automatic drain_all();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int count, int sidle, int rstall);
        @(negedge clk);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int k = 0; k < count; k++)
        begin
            pending_accesses.push_back(random_access());
            // halfway: hold the sender until everything so far has come back
            if (k == count / 2)
                drain_all();
        end
        drain_all();
    endtask

    // input driver: predicts on acceptance, then presents the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(emulate_access(presented));
            if (!in_valid || !in_stall)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    presented         = pending_accesses.pop_front();
                    in_valid         <= 1'b1;
                    mode             <= presented.mode;
                    reg_offset       <= presented.offset;
                    width_code       <= presented.width;
                    write_data       <= presented.data;
                    memory_decode_on <= presented.mem_on;
                    io_decode_on     <= presented.io_on;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // output monitor: random stall, compare each accepted result word
    always @(posedge clk or negedge rst_n)
    begin
        reply_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, actual %b %h",
                             $time, claimed, read_data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("claimed", 32'(exp_r.claimed), 32'(claimed));
                    check_field("read_data", exp_r.rdata, read_data);
                    check_field("write_dropped", 32'(exp_r.dropped), 32'(write_dropped));
                    check_field("rom_unmap", 32'(exp_r.unmap), 32'(rom_unmap));
                    check_field("rom_map", 32'(exp_r.mapped), 32'(rom_map));
                    check_field("rom_hw_enable_pulse", 32'(exp_r.pulse),
                                32'(rom_hw_enable_pulse));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // stimulus sequence
    initial
    begin
        logic [LAYOUT_W-1:0] lay;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed layout: 64-bit pair, io, mmio32, odd unused code, widest mmio32
        write_reg(CFG_BRIDGE_HEADER, LAYOUT_W'(0));
        write_reg(CFG_BAR_LAYOUT, {6'd63, 1'b1, BT_MMIO32,
                                   6'd63, 1'b1, 3'd6,
                                   6'd20, 1'b0, BT_MMIO32,
                                   6'd4,  1'b0, BT_IO,
                                   6'd0,  1'b0, BT_UPPER,
                                   6'd12, 1'b1, BT_MMIO64});
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'(ROM_LG_MIN));
        @(negedge clk);

        // 64-bit pair written and read back, upper half under memory decode
        queue_access(MODE_WRITE, 8'h10, W_WORD, 32'hffffffff, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h14, W_WORD, 32'hffffffff, 1'b0, 1'b1);
        queue_access(MODE_WRITE, 8'h14, W_WORD, 32'h0, 1'b1, 1'b0);
        queue_access(MODE_READ,  8'h10, W_WORD, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_READ,  8'h14, W_WORD, 32'h0, 1'b1, 1'b1);
        // io bar gated by io decode, limited to 16 bits
        queue_access(MODE_WRITE, 8'h18, W_WORD, 32'h12345678, 1'b0, 1'b1);
        queue_access(MODE_WRITE, 8'h18, W_WORD, 32'hffffffff, 1'b1, 1'b0);
        queue_access(MODE_READ,  8'h18, W_DWORD, 32'h0, 1'b0, 1'b0);
        // mmio32 gated by memory decode, wrong widths dropped
        queue_access(MODE_WRITE, 8'h1c, W_WORD, 32'hdeadbeef, 1'b1, 1'b0);
        queue_access(MODE_WRITE, 8'h1c, W_HALF, 32'hdeadbeef, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h18, W_DWORD, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h1c, W_WORD, 32'hdeadbeef, 1'b0, 1'b0);
        // misaligned reads and writes
        queue_access(MODE_READ,  8'h12, W_WORD, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h1a, W_WORD, 32'hffffffff, 1'b0, 1'b0);
        // narrow reads inside a register return its low bytes
        queue_access(MODE_READ,  8'h1e, W_HALF, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_READ,  8'h13, W_BYTE, 32'h0, 1'b0, 1'b0);
        // unused bar and widest mmio32
        queue_access(MODE_WRITE, 8'h20, W_WORD, 32'hffffffff, 1'b0, 1'b0);
        queue_access(MODE_READ,  8'h20, W_WORD, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h24, W_WORD, 32'hffffffff, 1'b0, 1'b0);
        queue_access(MODE_READ,  8'h24, W_WORD, 32'h0, 1'b0, 1'b0);
        // unclaimed offsets
        queue_access(MODE_WRITE, 8'hff, W_BYTE, 32'hffffffff, 1'b1, 1'b1);
        queue_access(MODE_READ,  8'h28, W_WORD, 32'h0, 1'b0, 1'b0);
        // rom: first enable, remap, wide read, narrow write
        queue_access(MODE_WRITE, 8'h30, W_WORD, 32'hffffffff, 1'b1, 1'b0);
        queue_access(MODE_WRITE, 8'h30, W_BYTE, 32'h00000801, 1'b1, 1'b0);
        queue_access(MODE_READ,  8'h30, W_DWORD, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_WRITE, 8'h32, W_HALF, 32'h0, 1'b0, 1'b0);
        queue_access(MODE_READ,  8'h31, W_BYTE, 32'h0, 1'b0, 1'b0);
        drain_all();

        // endpoint, random layout, smallest rom
        write_reg(CFG_BAR_LAYOUT, random_layout());
        run_phase(90, 0, 0);

        // bridge header, largest rom
        write_reg(CFG_BRIDGE_HEADER, LAYOUT_W'(1));
        write_reg(CFG_BAR_LAYOUT, random_layout());
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'(31));
        run_phase(90, 80, 0);

        // every layout bit set: all codes read as unused
        write_reg(CFG_BRIDGE_HEADER, LAYOUT_W'(0));
        write_reg(CFG_BAR_LAYOUT, '1);
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'(20));
        run_phase(30, 0, 80);

        // empty layout
        write_reg(CFG_BAR_LAYOUT, '0);
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'(16));
        run_phase(30, 16, 16);

        write_reg(CFG_BRIDGE_HEADER, LAYOUT_W'(1));
        write_reg(CFG_BAR_LAYOUT, random_layout());
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'($urandom_range(31, 11)));
        run_phase(105, 0, 80);

        // endpoint with an upper half at bar 0
        lay      = random_layout();
        lay[2:0] = BT_UPPER;
        write_reg(CFG_BRIDGE_HEADER, LAYOUT_W'(0));
        write_reg(CFG_BAR_LAYOUT, lay);
        write_reg(CFG_ROM_SIZE_LOG2, LAYOUT_W'($urandom_range(31, 11)));
        run_phase(105, 16, 16);

        repeat (10) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/pcibar_pkg.sv
src/pcibar_ram.sv
src/pci_bar_config_registers.sv
tb/tb_pci_bar_config_registers.sv
